// ===== rtl/cnu_pkg.sv =====
// Shared constants and the group descriptor type of the min-sum check node update.
package cnu_pkg;

    // Largest number of messages in one check node group.
    localparam int MAX_DEGREE  = 32;
    // Width of one LLR message.
    localparam int MSG_WIDTH   = 8;
    // Number of finished groups that can wait between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    localparam int MAG_W  = MSG_WIDTH - 1;
    localparam int POS_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // Everything the back end needs to emit the results of one group.
    typedef struct packed {
        logic [MAG_W-1:0]      min_first;
        logic [MAG_W-1:0]      min_second;
        logic [POS_W-1:0]      min_pos;
        logic                  parity;
        logic [CNT_W-1:0]      count;
        logic                  overflow;
        logic [MAX_DEGREE-1:0] signs;
    } t_group;

endpackage

// ===== rtl/cnu_front.sv =====
// Front end: takes incoming messages and tracks the two minima, signs and parity.
module cnu_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [cnu_pkg::MSG_WIDTH-1:0] i_msg_value,
    input  logic                                i_msg_last,
    output logic                                o_push,
    output cnu_pkg::t_group                     o_group
);
    import cnu_pkg::*;

    logic [MAG_W-1:0]      r_min_first,  n_min_first;
    logic [MAG_W-1:0]      r_min_second, n_min_second;
    logic [POS_W-1:0]      r_min_pos,    n_min_pos;
    logic                  r_parity,     n_parity;
    logic [CNT_W-1:0]      r_count,      n_count;
    logic                  r_overflow,   n_overflow;
    logic [MAX_DEGREE-1:0] r_signs,      n_signs;

    logic                 neg;
    logic [MSG_WIDTH-1:0] abs_val;
    logic [MAG_W-1:0]     mag;

    // Sign and saturated magnitude of the incoming message; zero is positive.
    always_comb begin
        neg     = i_msg_value[MSG_WIDTH-1];
        abs_val = neg ? (~i_msg_value + 1'b1) : i_msg_value;
        mag     = abs_val[MSG_WIDTH-1] ? MAG_MAX : abs_val[MAG_W-1:0];
    end

    // Update the running minima; an equal magnitude keeps the earlier one.
    always_comb begin
        n_min_first  = r_min_first;
        n_min_second = r_min_second;
        n_min_pos    = r_min_pos;
        n_parity     = r_parity;
        n_count      = r_count;
        n_overflow   = r_overflow;
        n_signs      = r_signs;
        if (i_accept) begin
            if (r_count < CNT_W'(MAX_DEGREE)) begin
                n_signs[r_count[POS_W-1:0]] = neg;
                n_parity = r_parity ^ neg;
                if (mag < r_min_first) begin
                    n_min_second = r_min_first;
                    n_min_first  = mag;
                    n_min_pos    = r_count[POS_W-1:0];
                end else if (mag < r_min_second) begin
                    n_min_second = mag;
                end
                n_count = r_count + 1'b1;
            end else begin
                n_overflow = 1'b1;
            end
        end
    end

    // The last beat of a group hands the finished summary to the queue.
    assign o_push             = i_accept & i_msg_last;
    assign o_group.min_first  = n_min_first;
    assign o_group.min_second = n_min_second;
    assign o_group.min_pos    = n_min_pos;
    assign o_group.parity     = n_parity;
    assign o_group.count      = n_count;
    assign o_group.overflow   = n_overflow;
    assign o_group.signs      = n_signs;

    // Group state returns to its reset value once the group is handed off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_min_first  <= MAG_MAX;
            r_min_second <= MAG_MAX;
            r_min_pos    <= '0;
            r_parity     <= 1'b0;
            r_count      <= '0;
            r_overflow   <= 1'b0;
        end else begin
            r_min_first  <= n_min_first;
            r_min_second <= n_min_second;
            r_min_pos    <= n_min_pos;
            r_parity     <= n_parity;
            r_count      <= n_count;
            r_overflow   <= n_overflow;
        end
    end

    // Sign bits are written before they are read and need no reset.
    always_ff @(posedge i_clk) begin
        r_signs <= n_signs;
    end

endmodule

// ===== rtl/cnu_queue.sv =====
// Short queue of finished group summaries between the front and the back end.
module cnu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cnu_pkg::t_group i_group,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cnu_pkg::t_group o_group
);
    import cnu_pkg::*;

    t_group            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_fill,   n_fill;

    assign o_full  = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_group = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // The front end is held off before the queue can overflow.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("group pushed into a full queue");

    // The back end only pops a waiting group.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("group popped from an empty queue");

    // Fill level follows the push and pop beats.
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("queue fill level lost a push");

endmodule

// ===== rtl/cnu_back.sv =====
// Back end: emits one extrinsic message per stored sign of a finished group.
module cnu_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  cnu_pkg::t_group                      i_group,
    output logic                                 o_pop,
    output logic                                 o_ext_valid,
    output logic signed [cnu_pkg::MSG_WIDTH-1:0] o_ext_value,
    output logic                                 o_ext_last,
    output logic                                 o_degree_overflow
);
    import cnu_pkg::*;

    logic                  r_active;
    t_group                r_grp;
    logic [CNT_W-1:0]      r_k;

    logic                  r_valid;
    logic [MSG_WIDTH-1:0]  r_value;
    logic                  r_last;
    logic                  r_ovf;

    logic                  k_last;
    logic [MAG_W-1:0]      m_sel;
    logic                  s_out;
    logic [MSG_WIDTH-1:0]  m_ext;

    // Pick the magnitude and sign of the current position.
    always_comb begin
        k_last = (r_k + 1'b1 == r_grp.count);
        m_sel  = (r_k[POS_W-1:0] == r_grp.min_pos) ? r_grp.min_second : r_grp.min_first;
        s_out  = r_grp.signs[0] ^ r_grp.parity;
        m_ext  = {1'b0, m_sel};
    end

    // Take the next group when idle or on the last beat of the current one.
    assign o_pop = !i_empty && (!r_active || k_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && k_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Group payload, position counter and sign shift line.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
            r_k   <= '0;
        end else if (r_active) begin
            r_grp.signs <= r_grp.signs >> 1;
            r_k         <= r_k + 1'b1;
        end
    end

    // Output register: one beat per position.
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_value <= s_out ? (~m_ext + 1'b1) : m_ext;
            r_last  <= k_last;
            r_ovf   <= r_grp.overflow;
        end
    end

    assign o_ext_valid       = r_valid;
    assign o_ext_value       = r_value;
    assign o_ext_last        = r_last;
    assign o_degree_overflow = r_ovf;

    // The position counter stays inside the group while emitting.
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_k < r_grp.count))
        else $error("emit position ran past the group size");

endmodule

// ===== rtl/two_min_check_node_update.sv =====
// Top level of the streaming min-sum check node update.
// Takes one message per cycle while busy is low; a group ends on msg_last.
// With the emitter idle, a group goes through the queue, the emitter's group
// register and the output register, then one result per cycle, one per message.
// busy rises while two finished groups wait for the emitter; results cannot
// be stalled. Synchronous active-low reset clears the minima, counts and queue.
module two_min_check_node_update (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [cnu_pkg::MSG_WIDTH-1:0] i_msg_value,
    input  logic                                 i_msg_last,
    output logic                                 o_ext_valid,
    output logic signed [cnu_pkg::MSG_WIDTH-1:0] o_ext_value,
    output logic                                 o_ext_last,
    output logic                                 o_degree_overflow
);
    import cnu_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_group grp_in;
    t_group grp_out;

    // An input beat is taken whenever the queue has room.
    assign busy   = q_full;
    assign accept = start & ~busy;

    cnu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_msg_value (i_msg_value),
        .i_msg_last  (i_msg_last),
        .o_push      (push),
        .o_group     (grp_in)
    );

    cnu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_group (grp_out)
    );

    cnu_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_group           (grp_out),
        .o_pop             (pop),
        .o_ext_valid       (o_ext_valid),
        .o_ext_value       (o_ext_value),
        .o_ext_last        (o_ext_last),
        .o_degree_overflow (o_degree_overflow)
    );

endmodule
